// ===== rtl/core/first_fit_block_allocator_assert.svh =====
// Assertion macros used by the allocator checker.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FFBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Types, constants and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int MAX_BLOCKS  = 64;
    localparam int META_BYTES  = 32;
    localparam int MAX_REQUEST = 100000000;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = 7;
    localparam int SIZE_W = 27;
    localparam int ADDR_W = 32;

    localparam logic [1:0] REQ_MALLOC  = 2'd0;
    localparam logic [1:0] REQ_CALLOC  = 2'd1;
    localparam logic [1:0] REQ_FREE    = 2'd2;
    localparam logic [1:0] REQ_REALLOC = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_MEM   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN  = 2'd3;

    localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [1:0] CFG_HEAP_LIMIT = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ADDR_WAIT,
        S_FIT_WAIT,
        S_APPEND,
        S_RELEASE,
        S_DONE
    } t_state;

    // Search token that walks down the cell chain.
    typedef struct packed {
        logic              valid;
        logic              fit;
        logic [SIZE_W-1:0] key_size;
        logic [ADDR_W-1:0] key_addr;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [SIZE_W-1:0] hit_size;
        logic [ADDR_W-1:0] hit_addr;
        logic              hit_free;
    } t_query;

    // Table write broadcast to all cells.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic              set_entry;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic              free;
    } t_cell_wr;

endpackage

// ===== rtl/core/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block manager for malloc, calloc, free and realloc.
// ----------------------------------------------------------------------------
// Requests enter on the i_in_* channel (valid/stall) and one result per
// request leaves on the o_out_* channel. A transaction completes when valid
// is high and stall is low. Requests are handled one at a time: o_in_stall
// is high from acceptance until the result is loaded into the output
// register. Each table search walks a chain of 64 cells, one cell per clock;
// a realloc that must move runs an address search followed by a first-fit
// search. While a result waits under i_out_stall, the next request is still
// accepted and processed; only its result waits. Reset clears the block
// count, statistics and handshake state and sets the registers to heap base
// 4096 and heap limit 16 MiB. Configuration writes use i_cfg_we, i_cfg_index
// and i_cfg_data; the user must make them only while idle, as the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_req_size,
    input  logic [31:0] i_elem_count,
    input  logic [31:0] i_block_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_address,
    output logic [26:0] o_copy_bytes,
    output logic [6:0]  o_free_blocks,
    output logic [32:0] o_free_bytes,
    output logic [6:0]  o_allocated_blocks,
    output logic [32:0] o_allocated_bytes,
    output logic [11:0] o_meta_bytes
);
    import ffba_pkg::*;

    t_state r_state, n_state;

    logic [31:0]       r_base, r_limit, r_top;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_free_cnt;
    logic [32:0]       r_free_bytes, r_alloc_bytes;

    logic [1:0]        r_type;
    logic [63:0]       r_asize;
    logic [31:0]       r_baddr;
    logic              r_move;
    logic [IDX_W-1:0]  r_old_idx;
    logic [SIZE_W-1:0] r_old_size;
    logic              r_old_free;
    logic [1:0]        r_status;
    logic [31:0]       r_raddr;
    logic [SIZE_W-1:0] r_copy;

    logic              r_out_valid;
    logic [1:0]        r_o_status;
    logic [31:0]       r_o_raddr;
    logic [SIZE_W-1:0] r_o_copy;
    logic [6:0]        r_o_fblk, r_o_ablk;
    logic [32:0]       r_o_fbytes, r_o_abytes;
    logic [11:0]       r_o_meta;

    t_query            q_in, q_out;
    t_cell_wr          wr;

    logic              in_acc, out_free, bad_size, alloc_req, in_place;
    logic [31:0]       used;
    logic [32:0]       need;
    logic [33:0]       endv;
    logic              no_room;
    logic              launch_fit, launch_addr;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign bad_size  = (r_asize == 64'd0) || (r_asize > 64'(MAX_REQUEST));
    // A realloc of null behaves as malloc; a free of null does nothing.
    assign alloc_req = (r_type == REQ_MALLOC) || (r_type == REQ_CALLOC) ||
                       ((r_type == REQ_REALLOC) && (r_baddr == 32'd0));
    assign in_place  = (64'(q_out.hit_size) >= r_asize) && (r_asize != 64'd0);

    // Growth check for appending a block at the heap top.
    assign used    = (r_top >= r_base) ? (r_top - r_base) : 32'd0;
    assign need    = 33'(META_BYTES) + 33'(r_asize[SIZE_W-1:0]);
    assign endv    = 34'(r_top) + 34'(need);
    assign no_room = (r_count >= CNT_W'(MAX_BLOCKS)) ||
                     ((34'(used) + 34'(need)) > 34'(r_limit)) ||
                     (endv > 34'h0FFFFFFFF) ||
                     ((33'(r_top) + 33'(META_BYTES)) == 33'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_PREP;
            end
            S_PREP: begin
                if (alloc_req) begin
                    n_state = bad_size ? S_DONE : S_FIT_WAIT;
                end else begin
                    n_state = (r_baddr == 32'd0) ? S_DONE : S_ADDR_WAIT;
                end
            end
            S_ADDR_WAIT: begin
                if (q_out.valid) begin
                    if (!q_out.hit || r_type == REQ_FREE || in_place || bad_size) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FIT_WAIT;
                    end
                end
            end
            S_FIT_WAIT: begin
                if (q_out.valid) begin
                    if (!q_out.hit) n_state = S_APPEND;
                    else            n_state = r_move ? S_RELEASE : S_DONE;
                end
            end
            S_APPEND: begin
                n_state = (!no_room && r_move) ? S_RELEASE : S_DONE;
            end
            S_RELEASE: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        launch_fit  = 1'b0;
        launch_addr = 1'b0;
        wr          = '0;
        unique case (r_state)
            S_PREP: begin
                launch_fit  = alloc_req && !bad_size;
                launch_addr = !alloc_req && (r_baddr != 32'd0);
            end
            S_ADDR_WAIT: begin
                if (q_out.valid && q_out.hit) begin
                    if (r_type == REQ_FREE) begin
                        wr.en   = !q_out.hit_free;
                        wr.idx  = q_out.hit_idx;
                        wr.free = 1'b1;
                    end else begin
                        launch_fit = !in_place && !bad_size;
                    end
                end
            end
            S_FIT_WAIT: begin
                wr.en   = q_out.valid && q_out.hit;
                wr.idx  = q_out.hit_idx;
                wr.free = 1'b0;
            end
            S_APPEND: begin
                wr.en        = !no_room;
                wr.idx       = r_count[IDX_W-1:0];
                wr.set_entry = 1'b1;
                wr.size      = r_asize[SIZE_W-1:0];
                wr.addr      = r_top + 32'(META_BYTES);
                wr.free      = 1'b0;
            end
            S_RELEASE: begin
                wr.en   = !r_old_free;
                wr.idx  = r_old_idx;
                wr.free = 1'b1;
            end
            default: begin
            end
        endcase
        q_in          = '0;
        q_in.valid    = launch_fit || launch_addr;
        q_in.fit      = launch_fit;
        q_in.key_size = r_asize[SIZE_W-1:0];
        q_in.key_addr = r_baddr;
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= 32'd4096;
            r_limit       <= 32'd16777216;
            r_top         <= 32'd4096;
            r_count       <= '0;
            r_free_cnt    <= '0;
            r_free_bytes  <= '0;
            r_alloc_bytes <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HEAP_BASE: begin
                        r_base <= i_cfg_data;
                        if (r_count == '0) r_top <= i_cfg_data;
                    end
                    CFG_HEAP_LIMIT: r_limit <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (wr.en) begin
                if (wr.set_entry) begin
                    r_count       <= r_count + 1'b1;
                    r_alloc_bytes <= r_alloc_bytes + 33'(r_asize[SIZE_W-1:0]);
                    r_top         <= endv[31:0];
                end else if (wr.free) begin
                    r_free_cnt <= r_free_cnt + 1'b1;
                    r_free_bytes <= r_free_bytes +
                        33'((r_state == S_RELEASE) ? r_old_size : q_out.hit_size);
                end else begin
                    r_free_cnt   <= r_free_cnt - 1'b1;
                    r_free_bytes <= r_free_bytes - 33'(q_out.hit_size);
                end
            end
        end
    end

    // Request and result working registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_type   <= i_req_type;
                    r_baddr  <= i_block_address;
                    r_asize  <= (i_req_type == REQ_CALLOC) ? (64'(i_req_size) *
                                64'(i_elem_count)) : 64'(i_req_size);
                    r_move   <= 1'b0;
                    r_status <= ST_OK;
                    r_raddr  <= '0;
                    r_copy   <= '0;
                end
            end
            S_PREP: begin
                if (alloc_req && bad_size) r_status <= ST_BAD_SIZE;
            end
            S_ADDR_WAIT: begin
                if (q_out.valid) begin
                    if (!q_out.hit) begin
                        r_status <= ST_UNKNOWN;
                    end else if (r_type == REQ_REALLOC) begin
                        if (in_place) begin
                            r_raddr <= r_baddr;
                        end else if (bad_size) begin
                            r_status <= ST_BAD_SIZE;
                        end else begin
                            r_move     <= 1'b1;
                            r_old_idx  <= q_out.hit_idx;
                            r_old_size <= q_out.hit_size;
                            r_old_free <= q_out.hit_free;
                        end
                    end
                end
            end
            S_FIT_WAIT: begin
                if (q_out.valid && q_out.hit) r_raddr <= q_out.hit_addr;
            end
            S_APPEND: begin
                if (no_room) r_status <= ST_NO_MEM;
                else         r_raddr  <= r_top + 32'(META_BYTES);
            end
            S_RELEASE: r_copy <= r_old_size;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_status <= r_status;
            r_o_raddr  <= r_raddr;
            r_o_copy   <= r_copy;
            r_o_fblk   <= r_free_cnt;
            r_o_fbytes <= r_free_bytes;
            r_o_ablk   <= r_count;
            r_o_abytes <= r_alloc_bytes;
            r_o_meta   <= 12'(32'(r_count) * 32'(META_BYTES));
        end
    end

    ffba_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_count (r_count),
        .i_wr    (wr),
        .i_q     (q_in),
        .o_q     (q_out)
    );

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_result_address   = r_o_raddr;
    assign o_copy_bytes       = r_o_copy;
    assign o_free_blocks      = r_o_fblk;
    assign o_free_bytes       = r_o_fbytes;
    assign o_allocated_blocks = r_o_ablk;
    assign o_allocated_bytes  = r_o_abytes;
    assign o_meta_bytes       = r_o_meta;

endmodule

// ===== rtl/core/ffba_cell.sv =====
// ----------------------------------------------------------------------------
// ffba_cell
// One block table entry with a search stage that compares and forwards.
// ----------------------------------------------------------------------------
module ffba_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ffba_pkg::IDX_W-1:0] i_index,
    input  logic [ffba_pkg::CNT_W-1:0] i_count,
    input  ffba_pkg::t_cell_wr         i_wr,
    input  ffba_pkg::t_query           i_q,
    output ffba_pkg::t_query           o_q
);
    import ffba_pkg::*;

    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_addr;
    logic              r_free;
    t_query            r_q;
    t_query            n_q;
    logic              live;
    logic              match;

    assign live  = CNT_W'(i_index) < i_count;
    assign match = i_q.fit ? (r_free && (r_size >= i_q.key_size))
                           : (r_addr == i_q.key_addr);

    always_comb begin
        n_q = i_q;
        // The first live entry that matches claims the token.
        if (i_q.valid && !i_q.hit && live && match) begin
            n_q.hit      = 1'b1;
            n_q.hit_idx  = i_index;
            n_q.hit_size = r_size;
            n_q.hit_addr = r_addr;
            n_q.hit_free = r_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else begin
            r_q <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_free <= i_wr.free;
            if (i_wr.set_entry) begin
                r_size <= i_wr.size;
                r_addr <= i_wr.addr;
            end
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/core/ffba_chain.sv =====
// ----------------------------------------------------------------------------
// ffba_chain
// Row of table cells; a search token moves one cell per clock.
// ----------------------------------------------------------------------------
module ffba_chain (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ffba_pkg::CNT_W-1:0] i_count,
    input  ffba_pkg::t_cell_wr         i_wr,
    input  ffba_pkg::t_query           i_q,
    output ffba_pkg::t_query           o_q
);
    import ffba_pkg::*;

    t_query q [0:MAX_BLOCKS];

    assign q[0] = i_q;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_count (i_count),
            .i_wr    (i_wr),
            .i_q     (q[g]),
            .o_q     (q[g+1])
        );
    end

    assign o_q = q[MAX_BLOCKS];

endmodule

// ===== rtl/core/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level assertions for the first-fit block allocator.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_assert.svh"

module ffba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_result_address,
    input logic [26:0] o_copy_bytes,
    input logic [6:0]  o_free_blocks,
    input logic [6:0]  o_allocated_blocks,
    input logic [11:0] o_meta_bytes
);
    import ffba_pkg::*;

    logic [11:0] meta_expect;

    assign meta_expect = 12'(32'(o_allocated_blocks) * 32'(META_BYTES));

    `FFBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped under stall")
    `FFBA_ASSERT_NOW(a_meta, i_clk, i_rst_n, o_out_valid, o_meta_bytes == meta_expect, "metadata bytes disagree with block count")
    `FFBA_ASSERT_NOW(a_free_le, i_clk, i_rst_n, o_out_valid, o_free_blocks <= o_allocated_blocks, "more free blocks than blocks")
    `FFBA_ASSERT_NOW(a_fail_null, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_result_address == 32'd0 && o_copy_bytes == 27'd0, "failed request returned an address or copy")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_status           (o_status),
    .o_result_address   (o_result_address),
    .o_copy_bytes       (o_copy_bytes),
    .o_free_blocks      (o_free_blocks),
    .o_allocated_blocks (o_allocated_blocks),
    .o_meta_bytes       (o_meta_bytes)
);
